// File: sv/sif_pkg.sv
// Shared types and constants for the segment intersection fraction core.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package sif_pkg;

	// Coordinate and intermediate widths, fixed by the 16-bit Q12.4 input fields
	localparam int COORD_W = 16;
	localparam int DIFF_W  = COORD_W + 1;   // b-a, d-c, c-a
	localparam int PROD_W  = 2 * DIFF_W;    // one cross-product term
	localparam int SUM_W   = PROD_W + 1;    // determinant / numerator
	localparam int MAG_W   = SUM_W - 1;     // magnitude of a sum
	localparam int FRAC_W  = 17;            // width of the fraction field

	localparam int FRAC_BITS_DEF = 16;

	// Control bundle handed from stage to stage and from cell to cell
	typedef struct packed {
		logic valid;
		logic parallel;
		logic sat;
	} sif_ctl_t;

endpackage

`default_nettype wire

// File: sv/sif_front.sv
// Front end: edge vectors, cross-product terms, magnitudes and saturation check.
// Five registered stages; uses sif_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sif_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               en,
	input  wire logic                               take,
	input  wire logic signed [sif_pkg::COORD_W-1:0] ax,
	input  wire logic signed [sif_pkg::COORD_W-1:0] ay,
	input  wire logic signed [sif_pkg::COORD_W-1:0] bx,
	input  wire logic signed [sif_pkg::COORD_W-1:0] by_coord,
	input  wire logic signed [sif_pkg::COORD_W-1:0] cx,
	input  wire logic signed [sif_pkg::COORD_W-1:0] cy,
	input  wire logic signed [sif_pkg::COORD_W-1:0] dx,
	input  wire logic signed [sif_pkg::COORD_W-1:0] dy,
	output sif_pkg::sif_ctl_t                       ctl,
	output logic [sif_pkg::MAG_W-1:0]               num_mag,
	output logic [sif_pkg::MAG_W-1:0]               det_mag
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [sif_pkg::DIFF_W-1:0] ux_s1, uy_s1, vx_s1, vy_s1, wx_s1, wy_s1;
	logic signed [sif_pkg::PROD_W-1:0] uvy_s2, uyvx_s2, wvy_s2, wyvx_s2;
	logic signed [sif_pkg::SUM_W-1:0]  det_s3, num_s3;
	logic [sif_pkg::MAG_W-1:0]         dmag_s4, nmag_s4, dmag_s5, nmag_s5;
	logic                              par_s4, par_s5, sat_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= sif_pkg::DIFF_W'(bx) - sif_pkg::DIFF_W'(ax);
			uy_s1 <= sif_pkg::DIFF_W'(by_coord) - sif_pkg::DIFF_W'(ay);
			vx_s1 <= sif_pkg::DIFF_W'(dx) - sif_pkg::DIFF_W'(cx);
			vy_s1 <= sif_pkg::DIFF_W'(dy) - sif_pkg::DIFF_W'(cy);
			wx_s1 <= sif_pkg::DIFF_W'(cx) - sif_pkg::DIFF_W'(ax);
			wy_s1 <= sif_pkg::DIFF_W'(cy) - sif_pkg::DIFF_W'(ay);

			uvy_s2  <= ux_s1 * vy_s1;
			uyvx_s2 <= uy_s1 * vx_s1;
			wvy_s2  <= wx_s1 * vy_s1;
			wyvx_s2 <= wy_s1 * vx_s1;

			det_s3 <= sif_pkg::SUM_W'(uvy_s2) - sif_pkg::SUM_W'(uyvx_s2);
			num_s3 <= sif_pkg::SUM_W'(wvy_s2) - sif_pkg::SUM_W'(wyvx_s2);

			dmag_s4 <= det_s3[sif_pkg::SUM_W-1] ? sif_pkg::MAG_W'(-det_s3)
			                                    : sif_pkg::MAG_W'(det_s3);
			nmag_s4 <= num_s3[sif_pkg::SUM_W-1] ? sif_pkg::MAG_W'(-num_s3)
			                                    : sif_pkg::MAG_W'(num_s3);
			par_s4  <= (det_s3 == '0);

			dmag_s5 <= dmag_s4;
			nmag_s5 <= nmag_s4;
			par_s5  <= par_s4;
			sat_s5  <= (nmag_s4 >= dmag_s4);
		end
	end

	assign ctl.valid    = v_s5;
	assign ctl.parallel = par_s5;
	assign ctl.sat      = sat_s5;
	assign num_mag      = nmag_s5;
	assign det_mag      = dmag_s5;

endmodule

`default_nettype wire

// File: sv/sif_div_cell.sv
// One cell of the restoring divider chain: one quotient bit per cell.
// Remainder, divisor, partial quotient and control advance to the next cell; uses sif_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sif_div_cell #(
	parameter int QW = sif_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire sif_pkg::sif_ctl_t            ctl_i,
	input  wire logic [sif_pkg::MAG_W-1:0]    rem_i,
	input  wire logic [sif_pkg::MAG_W-1:0]    div_i,
	input  wire logic [QW-1:0]                quo_i,
	output sif_pkg::sif_ctl_t                 ctl_o,
	output logic [sif_pkg::MAG_W-1:0]         rem_o,
	output logic [sif_pkg::MAG_W-1:0]         div_o,
	output logic [QW-1:0]                     quo_o
);

	logic [sif_pkg::MAG_W:0] trial;
	logic [sif_pkg::MAG_W:0] diff;
	logic                    ge;
	logic                    valid_q;
	logic                    parallel_q;
	logic                    sat_q;

	// Shift the partial remainder and try subtracting the divisor
	assign trial = {rem_i, 1'b0};
	assign diff  = trial - {1'b0, div_i};
	assign ge    = (trial >= {1'b0, div_i});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctl_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			parallel_q <= ctl_i.parallel;
			sat_q      <= ctl_i.sat;
			rem_o      <= ge ? diff[sif_pkg::MAG_W-1:0] : trial[sif_pkg::MAG_W-1:0];
			div_o      <= div_i;
			quo_o      <= {quo_i[QW-2:0], ge};
		end
	end

	assign ctl_o = {valid_q, parallel_q, sat_q};

endmodule

`default_nettype wire

// File: sv/segment_intersection_fraction_core.sv
// Segment intersection fraction: top level with front end, divider cell chain and output skid.
// Depends on sif_pkg, sif_front and sif_div_cell.
//
// Usage:
//   Segment channel (seg_valid / seg_stall) carries the four endpoints a, b, c, d in
//   signed Q12.4. Result channel (res_valid / res_stall) returns fraction, the distance
//   from a to the crossing of the two lines along a-b in Q1.FRAC_BITS, truncated and
//   saturated at 1.0, plus the parallel flag (fraction is 0 when it is set).
//   A transaction moves when valid is high and stall is low.
//   From acceptance to res_valid a transaction passes through, in order,
//   five front-end stages, one restoring-divider cell per quotient bit, one output register.
//   Throughput: one transaction per cycle while the skid is empty; the chain then advances.
//   When the receiver stalls, the output register holds its result and the next result
//   leaving the chain parks in a one-entry skid; while the skid is occupied the whole
//   pipeline holds and seg_stall is high. Once the held result is taken, the skid drains
//   and seg_stall drops the following cycle.
//   Reset (arst_n low) clears every valid bit; results in flight are dropped.
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection_fraction_core #(
	parameter int FRAC_BITS = sif_pkg::FRAC_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               seg_valid,
	output logic                                    seg_stall,
	input  wire logic signed [sif_pkg::COORD_W-1:0] ax,
	input  wire logic signed [sif_pkg::COORD_W-1:0] ay,
	input  wire logic signed [sif_pkg::COORD_W-1:0] bx,
	input  wire logic signed [sif_pkg::COORD_W-1:0] by_coord,
	input  wire logic signed [sif_pkg::COORD_W-1:0] cx,
	input  wire logic signed [sif_pkg::COORD_W-1:0] cy,
	input  wire logic signed [sif_pkg::COORD_W-1:0] dx,
	input  wire logic signed [sif_pkg::COORD_W-1:0] dy,
	output logic                                    res_valid,
	input  wire logic                               res_stall,
	output logic [sif_pkg::FRAC_W-1:0]              fraction,
	output logic                                    parallel
);

	localparam int WIDE_W = (FRAC_BITS + 1 > sif_pkg::FRAC_W) ? FRAC_BITS + 1 : sif_pkg::FRAC_W;

	logic en;
	logic seg_take;
	logic res_take;
	logic leave;

	sif_pkg::sif_ctl_t         ctl_c [FRAC_BITS+1];
	logic [sif_pkg::MAG_W-1:0] rem_c [FRAC_BITS+1];
	logic [sif_pkg::MAG_W-1:0] div_c [FRAC_BITS+1];
	logic [FRAC_BITS-1:0]      quo_c [FRAC_BITS+1];

	logic [FRAC_BITS:0]        frac_full;
	logic [WIDE_W-1:0]         frac_wide;
	logic [sif_pkg::FRAC_W-1:0] frac_new;

	logic                       out_v_q, skid_v_q;
	logic [sif_pkg::FRAC_W-1:0] out_frac_q, skid_frac_q;
	logic                       out_par_q, skid_par_q;

	// Pipeline holds only while the skid is occupied
	assign en        = !skid_v_q;
	assign seg_stall = skid_v_q;
	assign seg_take  = seg_valid && !seg_stall;
	assign res_take  = out_v_q && !res_stall;

	sif_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.take     (seg_take),
		.ax       (ax),
		.ay       (ay),
		.bx       (bx),
		.by_coord (by_coord),
		.cx       (cx),
		.cy       (cy),
		.dx       (dx),
		.dy       (dy),
		.ctl      (ctl_c[0]),
		.num_mag  (rem_c[0]),
		.det_mag  (div_c[0])
	);

	assign quo_c[0] = '0;

	for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
		sif_div_cell #(
			.QW (FRAC_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (ctl_c[i]),
			.rem_i  (rem_c[i]),
			.div_i  (div_c[i]),
			.quo_i  (quo_c[i]),
			.ctl_o  (ctl_c[i+1]),
			.rem_o  (rem_c[i+1]),
			.div_o  (div_c[i+1]),
			.quo_o  (quo_c[i+1])
		);
	end

	always_comb begin
		if (ctl_c[FRAC_BITS].parallel) begin
			frac_full = '0;
		end else if (ctl_c[FRAC_BITS].sat) begin
			frac_full = {1'b1, {FRAC_BITS{1'b0}}};
		end else begin
			frac_full = {1'b0, quo_c[FRAC_BITS]};
		end
	end

	// Keep the low field bits, zero-extend for narrow settings
	assign frac_wide = WIDE_W'(frac_full);
	assign frac_new  = frac_wide[sif_pkg::FRAC_W-1:0];
	assign leave     = en && ctl_c[FRAC_BITS].valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || res_take) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= leave;
				end
			end else if (leave) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || res_take) begin
			if (skid_v_q) begin
				out_frac_q <= skid_frac_q;
				out_par_q  <= skid_par_q;
			end else if (leave) begin
				out_frac_q <= frac_new;
				out_par_q  <= ctl_c[FRAC_BITS].parallel;
			end
		end else if (leave) begin
			skid_frac_q <= frac_new;
			skid_par_q  <= ctl_c[FRAC_BITS].parallel;
		end
	end

	assign res_valid = out_v_q;
	assign fraction  = out_frac_q;
	assign parallel  = out_par_q;

	// A parallel result always reports a zero fraction
	a_par_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && parallel |-> fraction == '0)
		else $error("parallel result with nonzero fraction");

	// The skid is only used behind an occupied output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid occupied with empty output register");

	// A parked result stays parked until the output register is taken
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && res_stall |=> skid_v_q && $stable(skid_frac_q))
		else $error("skid lost its entry while the receiver stalled");

endmodule

`default_nettype wire
